[design/pcf_pkg.sv]
// Shared constants, arithmetic constants and helper functions of the pair cutoff unit.
package pcf_pkg;

    localparam int CORDIC_STAGES_DEF = 16;
    localparam int DIST_W  = 24;
    localparam int RECIP_W = 24;
    localparam int GAMMA_W = 24;
    localparam int RES_W   = 32;
    localparam int ANG_W   = 34;

    localparam logic signed [ANG_W-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;
    localparam logic signed [31:0]      HALF_PI_Q30     = 32'sd1686629713;

    // Clamp to the int32 range
    function automatic logic signed [RES_W-1:0] sat32(input logic signed [79:0] v);
        logic signed [RES_W-1:0] r;
        if (v > 80'sd2147483647)
            r = 32'sh7FFFFFFF;
        else if (v < -80'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[RES_W-1:0];
        return r;
    endfunction

    // atan(2^-i) in binary angle units, full turn = 2^32
    function automatic logic [31:0] atan_entry(input int i);
        logic [31:0] r;
        case (i)
            0:  r = 32'h20000000;
            1:  r = 32'h12E4051E;
            2:  r = 32'h09FB385B;
            3:  r = 32'h051111D4;
            4:  r = 32'h028B0D43;
            5:  r = 32'h0145D7E1;
            6:  r = 32'h00A2F61E;
            7:  r = 32'h00517C55;
            8:  r = 32'h0028BE53;
            9:  r = 32'h00145F2F;
            10: r = 32'h000A2F98;
            11: r = 32'h000517CC;
            12: r = 32'h00028BE6;
            13: r = 32'h000145F3;
            14: r = 32'h0000A2FA;
            15: r = 32'h0000517D;
            16: r = 32'h000028BE;
            17: r = 32'h0000145F;
            18: r = 32'h00000A30;
            19: r = 32'h00000518;
            20: r = 32'h0000028C;
            21: r = 32'h00000146;
            22: r = 32'h000000A3;
            23: r = 32'h00000051;
            24: r = 32'h00000029;
            25: r = 32'h00000014;
            26: r = 32'h0000000A;
            27: r = 32'h00000005;
            28: r = 32'h00000003;
            29: r = 32'h00000001;
            30: r = 32'h00000001;
            default: r = 32'h00000000;
        endcase
        return r;
    endfunction

endpackage

[design/pcf_in_if.sv]
// Input channel: one pair distance per transaction.
interface pcf_in_if import pcf_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [DIST_W-1:0]  distance;
    logic               pair_valid;
    logic               batch_last;

    modport source (output valid, distance, pair_valid, batch_last, input ready);
    modport sink   (input valid, distance, pair_valid, batch_last, output ready);
endinterface

[design/pcf_out_if.sv]
// Output channel: cutoff value and slope per transaction.
interface pcf_out_if import pcf_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [RES_W-1:0] cutoff_value;
    logic signed [RES_W-1:0] cutoff_slope;
    logic                    last_out;

    modport source (output valid, cutoff_value, cutoff_slope, last_out, input ready);
    modport sink   (input valid, cutoff_value, cutoff_slope, last_out, output ready);
endinterface

[design/pcf_cordic.sv]
// Pipelined rotation-mode CORDIC, one stage per register.
module pcf_cordic import pcf_pkg::*; #(
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
    input  logic                    clk,
    input  logic                    en,
    input  logic signed [ANG_W-1:0] ang,
    output logic signed [ANG_W-1:0] cos_q30,
    output logic signed [ANG_W-1:0] sin_q30
);

    logic signed [ANG_W-1:0] cx_reg [0:CORDIC_STAGES-1];
    logic signed [ANG_W-1:0] cy_reg [0:CORDIC_STAGES-1];
    logic signed [ANG_W-1:0] cz_reg [0:CORDIC_STAGES-1];
    logic signed [ANG_W-1:0] cx_in  [0:CORDIC_STAGES-1];
    logic signed [ANG_W-1:0] cy_in  [0:CORDIC_STAGES-1];
    logic signed [ANG_W-1:0] cz_in  [0:CORDIC_STAGES-1];

    genvar i;
    generate
        for (i = 0; i < CORDIC_STAGES; i++)
        begin : g_stage
            localparam logic signed [ANG_W-1:0] ATAN = $signed({2'b00, atan_entry(i)});
            if (i == 0)
            begin : g_first
                assign cx_in[i] = CORDIC_GAIN_Q30;
                assign cy_in[i] = '0;
                assign cz_in[i] = ang;
            end
            else
            begin : g_next
                assign cx_in[i] = cx_reg[i-1];
                assign cy_in[i] = cy_reg[i-1];
                assign cz_in[i] = cz_reg[i-1];
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    if (cz_in[i] >= 0)
                    begin
                        cx_reg[i] <= cx_in[i] - (cy_in[i] >>> i);
                        cy_reg[i] <= cy_in[i] + (cx_in[i] >>> i);
                        cz_reg[i] <= cz_in[i] - ATAN;
                    end
                    else
                    begin
                        cx_reg[i] <= cx_in[i] + (cy_in[i] >>> i);
                        cy_reg[i] <= cy_in[i] - (cx_in[i] >>> i);
                        cz_reg[i] <= cz_in[i] + ATAN;
                    end
                end
            end
        end
    endgenerate

    assign cos_q30 = cx_reg[CORDIC_STAGES-1];
    assign sin_q30 = cy_reg[CORDIC_STAGES-1];

endmodule

[design/pcf_poly.sv]
// Polynomial cutoff: power chain, products and saturation, padded to match the CORDIC path.
module pcf_poly import pcf_pkg::*; #(
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
    input  logic                      clk,
    input  logic                      en,
    input  logic [30:0]               x,
    input  logic signed [GAMMA_W-1:0] gamma,
    input  logic signed [39:0]        k,
    output logic signed [RES_W-1:0]   value,
    output logic signed [RES_W-1:0]   slope
);

    localparam int PAD = CORDIC_STAGES - 4;

    logic [61:0] m1, m2, m3, m4;
    logic [30:0] x1_reg, x2_reg, xa_reg, x4_reg, x4b_reg, xb_reg, x5_reg, x5b_reg, x6_reg;
    logic signed [31:0] diff_reg;
    logic signed [25:0] dsh;
    logic signed [24:0] g1;
    logic signed [55:0] a_reg;
    logic signed [56:0] b_reg;
    logic signed [65:0] sp_reg;
    logic signed [57:0] vsum;
    logic signed [RES_W-1:0] val_reg, slp_reg;
    logic signed [RES_W-1:0] pad_val_reg [0:PAD-1];
    logic signed [RES_W-1:0] pad_slp_reg [0:PAD-1];

    assign m1   = x * x;
    assign m2   = x2_reg * x2_reg;
    assign m3   = x4_reg * xa_reg;
    assign m4   = x5_reg * xb_reg;
    assign g1   = 25'(gamma) + 25'sd65536;
    assign dsh  = 26'(diff_reg >>> 6);
    assign vsum = (58'sd1 <<< 46) + 58'(a_reg) - 58'(b_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x2_reg   <= m1[60:30];
            x1_reg   <= x;
            x4_reg   <= m2[60:30];
            xa_reg   <= x1_reg;
            x5_reg   <= m3[60:30];
            x4b_reg  <= x4_reg;
            xb_reg   <= xa_reg;
            x5b_reg  <= x5_reg;
            x6_reg   <= m4[60:30];
            diff_reg <= $signed({1'b0, x5_reg}) - $signed({1'b0, x4b_reg});
            a_reg    <= gamma * $signed({1'b0, x6_reg});
            b_reg    <= g1 * $signed({1'b0, x5b_reg});
            sp_reg   <= k * dsh;
            val_reg  <= sat32(80'(vsum >>> 22));
            slp_reg  <= sat32(80'(sp_reg >>> 24));
            pad_val_reg[0] <= val_reg;
            pad_slp_reg[0] <= slp_reg;
            for (int j = 1; j < PAD; j++)
            begin
                pad_val_reg[j] <= pad_val_reg[j-1];
                pad_slp_reg[j] <= pad_slp_reg[j-1];
            end
        end
    end

    assign value = pad_val_reg[PAD-1];
    assign slope = pad_slp_reg[PAD-1];

endmodule

[design/pair_cutoff_function_unit.sv]
// Top level of the pair cutoff unit: config registers, pipeline control and cosine post stages.
//
//   port      direction  transaction
//   in_ch     sink       distance, pair_valid, batch_last
//   out_ch    source     cutoff_value, cutoff_slope, last_out
//   APB       slave      mode, cutoff_recip, gamma at 0x0, 0x4, 0x8
//
// One pair enters per cycle while out_ch does not stall; the path is the CORDIC pipeline
// plus two front stages (product, clamp/fold) and three back stages (post multiplies, output).
// rst_n clears config to its reset values and empties all valid bits.
// A stall at out_ch freezes every stage together; in_ch.ready drops while the output holds.
module pair_cutoff_function_unit import pcf_pkg::*; #(
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    pcf_in_if.sink      in_ch,
    pcf_out_if.source   out_ch
);

    localparam int DEPTH = CORDIC_STAGES + 4;
    localparam logic [1:0] REG_MODE  = 2'd0;
    localparam logic [1:0] REG_RECIP = 2'd1;
    localparam logic [1:0] REG_GAMMA = 2'd2;
    localparam logic       MODE_COS  = 1'b0;

    typedef struct packed {
        logic pv;
        logic last;
        logic flip;
    } side_t;

    logic                      mode_reg;
    logic [RECIP_W-1:0]        recip_reg;
    logic signed [GAMMA_W-1:0] gamma_reg;
    logic signed [48:0]        g1g_reg;
    logic signed [39:0]        k_reg;
    logic signed [24:0]        g1;
    logic signed [57:0]        kprod;
    logic                      wr;
    logic                      adv;

    logic                      vld_reg [0:DEPTH-1];
    side_t                     sb_reg  [0:DEPTH-1];
    logic [47:0]               prod_reg;
    logic [30:0]               x_reg;
    logic signed [ANG_W-1:0]   ang_reg;
    logic [30:0]               xc;
    logic [31:0]               ang2;
    logic                      fold;

    logic signed [ANG_W-1:0]   cos_q30, sin_q30, cval;
    logic signed [ANG_W-1:0]   cv_reg, cv2_reg;
    logic signed [58:0]        tp_reg;
    logic signed [34:0]        t;
    logic signed [66:0]        mp_reg;
    logic signed [RES_W-1:0]   poly_val, poly_slp;

    logic                      out_vld_reg;
    logic signed [RES_W-1:0]   val_reg, slp_reg;
    logic                      last_reg;

    // Config port
    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_COS;
            recip_reg <= 24'd1048576;
            gamma_reg <= 24'sd131072;
        end
        else if (wr)
        begin
            case (paddr[3:2])
                REG_MODE:  mode_reg  <= pwdata[0];
                REG_RECIP: recip_reg <= pwdata[RECIP_W-1:0];
                REG_GAMMA: gamma_reg <= $signed(pwdata[GAMMA_W-1:0]);
                default:   ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_MODE:  prdata = {31'b0, mode_reg};
            REG_RECIP: prdata = {8'b0, recip_reg};
            REG_GAMMA: prdata = 32'(gamma_reg);
            default:   prdata = '0;
        endcase
    end

    // Polynomial slope gain follows config; user keeps it settled between batches (unchecked)
    assign g1    = 25'(gamma_reg) + 25'sd65536;
    assign kprod = (g1g_reg >>> 16) * $signed({1'b0, recip_reg});

    always_ff @(posedge clk)
    begin
        g1g_reg <= g1 * gamma_reg;
        k_reg   <= 40'(kprod >>> 16);
    end

    // Pipeline control: the whole pipe moves when the output register is empty or being taken
    assign adv         = !out_vld_reg || out_ch.ready;
    assign in_ch.ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < DEPTH; j++)
                vld_reg[j] <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg[0] <= in_ch.valid;
            for (int j = 1; j < DEPTH; j++)
                vld_reg[j] <= vld_reg[j-1];
            out_vld_reg <= vld_reg[DEPTH-1];
        end
    end

    // Clamp x to one and fold the angle into the first quadrant
    assign xc   = (prod_reg[47:6] > 42'd1073741824) ? 31'd1073741824 : prod_reg[36:6];
    assign ang2 = {xc, 1'b0};
    assign fold = ang2 > 32'd1073741824;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prod_reg <= in_ch.distance * recip_reg;
            sb_reg[0] <= '{pv: in_ch.pair_valid, last: in_ch.batch_last, flip: 1'b0};
            x_reg    <= xc;
            ang_reg  <= fold ? $signed(34'(33'h080000000 - 33'(ang2))) : $signed(34'(ang2));
            sb_reg[1] <= '{pv: sb_reg[0].pv, last: sb_reg[0].last, flip: fold};
            for (int j = 2; j < DEPTH; j++)
                sb_reg[j] <= sb_reg[j-1];
        end
    end

    pcf_cordic #(
        .CORDIC_STAGES(CORDIC_STAGES)
    ) u_cordic (
        .clk    (clk),
        .en     (adv),
        .ang    (ang_reg),
        .cos_q30(cos_q30),
        .sin_q30(sin_q30)
    );

    pcf_poly #(
        .CORDIC_STAGES(CORDIC_STAGES)
    ) u_poly (
        .clk  (clk),
        .en   (adv),
        .x    (x_reg),
        .gamma(gamma_reg),
        .k    (k_reg),
        .value(poly_val),
        .slope(poly_slp)
    );

    // Cosine post stages
    assign cval = sb_reg[CORDIC_STAGES+1].flip ? -cos_q30 : cos_q30;
    assign t    = 35'(tp_reg >>> 24);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cv_reg  <= (34'sd1073741824 + cval) >>> 7;
            tp_reg  <= sin_q30 * $signed({1'b0, recip_reg});
            cv2_reg <= cv_reg;
            mp_reg  <= t * HALF_PI_Q30;
        end
    end

    // Output register: select form, zero invalid pairs
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            last_reg <= sb_reg[DEPTH-1].last;
            if (!sb_reg[DEPTH-1].pv)
            begin
                val_reg <= '0;
                slp_reg <= '0;
            end
            else if (mode_reg == MODE_COS)
            begin
                val_reg <= sat32(80'(cv2_reg));
                slp_reg <= sat32(-(80'(mp_reg >>> 36)));
            end
            else
            begin
                val_reg <= poly_val;
                slp_reg <= poly_slp;
            end
        end
    end

    assign out_ch.valid        = out_vld_reg;
    assign out_ch.cutoff_value = val_reg;
    assign out_ch.cutoff_slope = slp_reg;
    assign out_ch.last_out     = last_reg;

endmodule

[dv/pair_cutoff_function_unit_tb.sv]
// Testbench for the pair cutoff unit: directed and random pairs checked against a predictor.
`timescale 1ns / 1ps

module pair_cutoff_function_unit_tb;
    import pcf_pkg::*;

    localparam int  MAX_CYCLES = 400000;
    localparam int  LATENCY    = CORDIC_STAGES_DEF + 5;
    localparam int  MODE_COS   = 0;
    localparam int  MODE_POLY  = 1;
    localparam logic [3:0] ADDR_MODE  = 4'h0;
    localparam logic [3:0] ADDR_RECIP = 4'h4;
    localparam logic [3:0] ADDR_GAMMA = 4'h8;
    localparam longint ONE_Q30 = 64'sd1073741824;

    // atan(2^-i), full turn = 2^32
    localparam longint ATAN_TURN [16] = '{
        64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
        64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
        64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
        64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D
    };

    typedef struct {
        logic signed [RES_W-1:0] value;
        logic signed [RES_W-1:0] slope;
        logic                    last;
    } cutoff_t;

    class cutoff_scoreboard;
        longint    mode_r;
        longint    recip_r;
        longint    gamma_r;
        cutoff_t   pending[$];
        int        failures;

        function new();
            mode_r   = MODE_COS;
            recip_r  = 1048576;
            gamma_r  = 131072;
            failures = 0;
        endfunction

        function logic signed [RES_W-1:0] clamp32(longint v);
            if (v > 64'sd2147483647)
                return 32'sh7FFFFFFF;
            if (v < -64'sd2147483648)
                return 32'sh80000000;
            return v[31:0];
        endfunction

        function void note_pair(logic [DIST_W-1:0] pair_dist, logic pv, logic bl);
            cutoff_t e;
            longint  xs, x, ang, cx, cy, z, nx, ny, c, s, t, value, slope;
            longint  x2, x4, x5, x6, g1, k;
            bit      flip;
            value = 0;
            slope = 0;
            if (pv) begin
                xs = (longint'(pair_dist) * recip_r) >>> 6;
                x  = (xs > ONE_Q30) ? ONE_Q30 : xs;
                if (mode_r == MODE_COS) begin
                    ang  = 2 * x;
                    flip = 0;
                    if (ang > ONE_Q30) begin
                        ang  = 2 * ONE_Q30 - ang;
                        flip = 1;
                    end
                    cx = longint'(CORDIC_GAIN_Q30);
                    cy = 0;
                    z  = ang;
                    for (int i = 0; i < CORDIC_STAGES_DEF; i++) begin
                        if (z >= 0) begin
                            nx = cx - (cy >>> i);
                            ny = cy + (cx >>> i);
                            z  = z - ATAN_TURN[i];
                        end
                        else begin
                            nx = cx + (cy >>> i);
                            ny = cy - (cx >>> i);
                            z  = z + ATAN_TURN[i];
                        end
                        cx = nx;
                        cy = ny;
                    end
                    c     = flip ? -cx : cx;
                    s     = cy;
                    value = (ONE_Q30 + c) >>> 7;
                    t     = (s * recip_r) >>> 24;
                    slope = -((t * longint'(HALF_PI_Q30)) >>> 36);
                end
                else begin
                    x2    = (x * x) >>> 30;
                    x4    = (x2 * x2) >>> 30;
                    x5    = (x4 * x) >>> 30;
                    x6    = (x5 * x) >>> 30;
                    g1    = gamma_r + 65536;
                    value = ((64'sd1 <<< 46) + gamma_r * x6 - g1 * x5) >>> 22;
                    k     = (((g1 * gamma_r) >>> 16) * recip_r) >>> 16;
                    slope = (k * ((x5 - x4) >>> 6)) >>> 24;
                end
            end
            e.value = clamp32(value);
            e.slope = clamp32(slope);
            e.last  = bl;
            pending.push_back(e);
        endfunction

        function void check_result(logic signed [RES_W-1:0] v, logic signed [RES_W-1:0] s,
                                   logic l);
            cutoff_t e;
            if (pending.size() == 0) begin
                $error("unexpected result value %0d slope %0d last %0b", v, s, l);
                failures++;
                return;
            end
            e = pending.pop_front();
            if (v !== e.value) begin
                $error("cutoff_value expected %0d actual %0d", e.value, v);
                failures++;
            end
            if (s !== e.slope) begin
                $error("cutoff_slope expected %0d actual %0d", e.slope, s);
                failures++;
            end
            if (l !== e.last) begin
                $error("last_out expected %0b actual %0b", e.last, l);
                failures++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    pcf_in_if  in_ch();
    pcf_out_if out_ch();

    pair_cutoff_function_unit dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .in_ch   (in_ch),
        .out_ch  (out_ch)
    );

    cutoff_scoreboard sb = new();
    int  hold_request = 0;
    int  cycle_count  = 0;

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > MAX_CYCLES) begin
            $display("pair_cutoff_function_unit_tb failed");
            $finish;
        end
    end

    function automatic int gap_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Receiver: random stalls, plus a long hold-off on request
    initial
    begin
        int stall_left;
        stall_left = 0;
        out_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever begin
            @(posedge clk);
            if (hold_request > 0) begin
                out_ch.ready <= 1'b0;
                hold_request--;
            end
            else if (stall_left > 0) begin
                out_ch.ready <= 1'b0;
                stall_left--;
            end
            else begin
                out_ch.ready <= 1'b1;
                stall_left = gap_length();
            end
        end
    end

    // Sample at the falling edge: these values hold through the next rising edge
    always @(negedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
            sb.check_result(out_ch.cutoff_value, out_ch.cutoff_slope, out_ch.last_out);
    end

    task automatic reg_write(logic [3:0] addr, logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (addr)
            ADDR_MODE:  sb.mode_r  = data[0];
            ADDR_RECIP: sb.recip_r = data[23:0];
            default:    sb.gamma_r = longint'($signed(data[23:0]));
        endcase
    endtask

    task automatic set_config(int m, logic [23:0] recip, logic [23:0] g);
        reg_write(ADDR_MODE, m);
        reg_write(ADDR_RECIP, {8'h0, recip});
        reg_write(ADDR_GAMMA, {8'h0, g});
    endtask

    task automatic send_pair(logic [DIST_W-1:0] pair_dist, logic pv, logic bl, bit use_gaps);
        bit taken;
        int gap;
        in_ch.valid      <= 1'b1;
        in_ch.distance   <= pair_dist;
        in_ch.pair_valid <= pv;
        in_ch.batch_last <= bl;
        forever begin
            @(negedge clk);
            taken = in_ch.ready;
            @(posedge clk);
            if (taken)
                break;
        end
        sb.note_pair(pair_dist, pv, bl);
        gap = use_gaps ? gap_length() : 0;
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    // Keep most distances inside the cutoff so x covers (0, 1)
    task automatic random_pairs(int count, bit use_gaps);
        longint bound;
        logic [DIST_W-1:0] pair_dist;
        for (int n = 0; n < count; n++) begin
            bound = (sb.recip_r == 0) ? 64'hFFFFFF : (64'sd1 <<< 36) / sb.recip_r;
            if (bound > 64'hFFFFFF)
                bound = 64'hFFFFFF;
            if ($urandom_range(0, 99) < 75)
                pair_dist = DIST_W'($urandom_range(0, int'(bound)));
            else
                pair_dist = DIST_W'($urandom);
            send_pair(pair_dist, $urandom_range(0, 99) < 88, 1'($urandom_range(0, 1)),
                      use_gaps);
        end
    endtask

    initial
    begin
        logic [23:0] directed [12] = '{24'h000000, 24'h000001, 24'h004000, 24'h008000,
                                       24'h00C000, 24'h00FFFF, 24'h010000, 24'h010001,
                                       24'h555555, 24'hAAAAAA, 24'hFFFFFE, 24'hFFFFFF};
        rst_n            <= 1'b0;
        psel             <= 1'b0;
        penable          <= 1'b0;
        pwrite           <= 1'b0;
        paddr            <= '0;
        pwdata           <= '0;
        in_ch.valid      <= 1'b0;
        in_ch.distance   <= '0;
        in_ch.pair_valid <= 1'b0;
        in_ch.batch_last <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset configuration: cosine mode, extremes of distance, invalid pairs
        foreach (directed[i])
            send_pair(directed[i], 1'b1, i[0], 1'b1);
        send_pair(24'hFFFFFF, 1'b0, 1'b1, 1'b1);
        send_pair(24'h008000, 1'b0, 1'b0, 1'b1);
        drain();

        set_config(MODE_POLY, 24'h100000, 24'h020000);
        foreach (directed[i])
            if (i % 2 == 0)
                send_pair(directed[i], 1'b1, 1'b1, 1'b1);
        drain();

        set_config(MODE_POLY, 24'hFFFFFF, 24'h800000);
        random_pairs(50, 1'b1);
        drain();

        set_config(MODE_POLY, 24'hFFFFFF, 24'h7FFFFF);
        random_pairs(50, 1'b1);
        drain();

        set_config(MODE_COS, 24'hFFFFFF, 24'h000000);
        random_pairs(50, 1'b1);
        drain();

        set_config(MODE_COS, 24'h000001, 24'h7FFFFF);
        random_pairs(30, 1'b1);
        drain();

        // Long receiver hold-off while pairs stream back to back
        set_config(MODE_COS, 24'($urandom_range(1, 24'hFFFFFF)), 24'($urandom));
        hold_request = 200;
        random_pairs(60, 1'b0);
        drain();

        for (int p = 0; p < 4; p++) begin
            set_config(p % 2, 24'($urandom_range(1, 24'hFFFFFF)), 24'($urandom));
            random_pairs(45, 1'b1);
            drain();
        end

        set_config(MODE_POLY, 24'($urandom_range(1, 24'h3FFFFF)),
                   24'($urandom_range(0, 24'h0FFFFF)));
        random_pairs(25, 1'b1);
        drain();

        if (sb.failures == 0)
            $display("pair_cutoff_function_unit_tb passed");
        else
            $display("pair_cutoff_function_unit_tb failed");
        $finish;
    end

endmodule
